// File: design/srp_pkg.sv
// Shared types and constants for the shelf packing sprite layout block.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package srp_pkg;

  // Configuration register file
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam int unsigned LIMIT_BITS    = 16;
  localparam int unsigned MARGIN_BITS   = 8;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MAX_SHEET_WIDTH  = 2'd0,
    REG_MAX_SHEET_HEIGHT = 2'd1,
    REG_X_MARGIN         = 2'd2,
    REG_Y_MARGIN         = 2'd3
  } cfg_reg_e;

  localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET  = 16'd4096;
  localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 8'd10;

  // Sheet numbers wrap at this width
  localparam int unsigned SHEET_BITS = 16;

  // Depth of the record queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Result kinds
  typedef enum logic {
    KIND_PLACE = 1'b0,
    KIND_SHEET = 1'b1
  } kind_e;

  // Back-end sequencing over the results of one record
  typedef enum logic [1:0] {
    PH_START,
    PH_PLACE,
    PH_FINAL
  } phase_e;

endpackage

// File: design/shelf_packing_sprite_layout.sv
// Top level of the shelf packing sprite layout block.
// Depends on srp_pkg, srp_front, srp_fifo and srp_back.
//
// Usage:
//   Configuration: write max_sheet_width (0), max_sheet_height (1), x_margin (2)
//   and y_margin (3) through cfg_we_i / cfg_idx_i / cfg_data_i while idle.
//   Input channel: one rectangle per transfer (width, height, group end).
//   Output channel: one result per transfer; each rectangle yields an optional
//   sheet-closed result (row wrap overflowed the sheet), its placement, and on
//   the last rectangle of a group the final sheet-closed result. final_res_o
//   marks the last result of a rectangle.
//   Path: from the input transfer, a rectangle's first result passes through
//   the record queue and then the output register.
//   Throughput: one rectangle per cycle while each gives a single placement
//   and the receiver is ready; a rectangle that closes sheets yields two or
//   three results, as the back end emits one result per cycle unless stalled.
//   A four-entry record queue sits between front and back; when the receiver
//   stalls, results hold in the output register, the queue fills and
//   in_ready_o drops.
//   Reset: registers return to 4096, 4096, 10, 10, the cursor returns to the
//   margins, sheet count clears, the queue empties and no result is pending.
`timescale 1ns / 1ps

module shelf_packing_sprite_layout
  import srp_pkg::*;
#(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [DIM_BITS-1:0]      rect_width_i,
  input  logic [DIM_BITS-1:0]      rect_height_i,
  input  logic                     group_end_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     kind_o,
  output logic [DIM_BITS+1:0]      x_offset_o,
  output logic [DIM_BITS+1:0]      y_offset_o,
  output logic [SHEET_BITS-1:0]    sheet_number_o,
  output logic [DIM_BITS+1:0]      sheet_width_o,
  output logic [DIM_BITS+1:0]      sheet_height_o,
  output logic                     final_res_o
);

  localparam int unsigned POS_BITS = DIM_BITS + 2;

  // One rectangle's worth of results, as handed from front to back
  typedef struct packed {
    logic                  wrap_close;
    logic                  last;
    logic [SHEET_BITS-1:0] prev_sheet;
    logic [SHEET_BITS-1:0] sheet;
    logic [POS_BITS-1:0]   px;
    logic [POS_BITS-1:0]   py;
    logic [POS_BITS-1:0]   cw;
    logic [POS_BITS-1:0]   ch;
    logic [POS_BITS-1:0]   fw;
    logic [POS_BITS-1:0]   fh;
  } rec_t;

  localparam int unsigned REC_BITS = $bits(rec_t);

  rec_t push_rec, head_rec;
  logic [REC_BITS-1:0] head_bits;
  logic q_full, q_push, q_pop, q_valid;

  srp_front #(
    .DIM_BITS (DIM_BITS),
    .rec_t    (rec_t)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .group_end_i   (group_end_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_rec_o       (push_rec)
  );

  srp_fifo #(
    .WIDTH (REC_BITS)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (push_rec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (head_bits)
  );

  assign head_rec = rec_t'(head_bits);

  srp_back #(
    .DIM_BITS (DIM_BITS),
    .rec_t    (rec_t)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (q_valid),
    .head_i         (head_rec),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .x_offset_o     (x_offset_o),
    .y_offset_o     (y_offset_o),
    .sheet_number_o (sheet_number_o),
    .sheet_width_o  (sheet_width_o),
    .sheet_height_o (sheet_height_o),
    .final_res_o    (final_res_o)
  );

endmodule

// File: design/srp_front.sv
// Front end: configuration registers, packing state and per-rectangle placement.
// Depends on srp_pkg; emits one record per rectangle into the record queue.
`timescale 1ns / 1ps

module srp_front
  import srp_pkg::*;
#(
  parameter int unsigned DIM_BITS = 16,
  parameter type rec_t = logic
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [DIM_BITS-1:0]      rect_width_i,
  input  logic [DIM_BITS-1:0]      rect_height_i,
  input  logic                     group_end_i,
  input  logic                     q_full_i,
  output logic                     q_push_o,
  output rec_t                     q_rec_o
);

  localparam int unsigned POS_BITS = DIM_BITS + 2;
  localparam int unsigned SUM_W    = (POS_BITS + 1 > LIMIT_BITS + 1) ? POS_BITS + 1
                                                                     : LIMIT_BITS + 1;

  // Clamp a widened sum to the position range
  function automatic logic [POS_BITS-1:0] sat_pos(input logic [SUM_W-1:0] v);
    logic [POS_BITS-1:0] r;
    r = (|v[SUM_W-1:POS_BITS]) ? {POS_BITS{1'b1}} : v[POS_BITS-1:0];
    return r;
  endfunction

  // Configuration registers
  logic [LIMIT_BITS-1:0]  max_w_q, max_h_q;
  logic [MARGIN_BITS-1:0] x_margin_q, y_margin_q;

  // Packing state
  logic [POS_BITS-1:0]   cursor_x_q, cursor_x_d;
  logic [POS_BITS-1:0]   cursor_y_q, cursor_y_d;
  logic [DIM_BITS-1:0]   row_height_q, row_height_d;
  logic [POS_BITS-1:0]   extent_w_q, extent_w_d;
  logic [POS_BITS-1:0]   extent_h_q, extent_h_d;
  logic [SHEET_BITS-1:0] sheet_q, sheet_d;

  logic                  accept;
  logic [SUM_W-1:0]      sum_x;
  logic                  wrap, close;
  logic [POS_BITS-1:0]   wrap_y, cy1, cx1, eh1, ew2, eh2, cy2, cx3, ew3, fin_y, eh4;
  logic [DIM_BITS-1:0]   rh1, rh3;
  logic [SHEET_BITS-1:0] sc2;
  logic [POS_BITS-1:0]   xm_pos, ym_pos;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;
  assign xm_pos     = POS_BITS'(x_margin_q);
  assign ym_pos     = POS_BITS'(y_margin_q);

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_w_q    <= LIMIT_RESET;
      max_h_q    <= LIMIT_RESET;
      x_margin_q <= MARGIN_RESET;
      y_margin_q <= MARGIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAX_SHEET_WIDTH:  max_w_q    <= cfg_data_i[LIMIT_BITS-1:0];
        REG_MAX_SHEET_HEIGHT: max_h_q    <= cfg_data_i[LIMIT_BITS-1:0];
        REG_X_MARGIN:         x_margin_q <= cfg_data_i[MARGIN_BITS-1:0];
        REG_Y_MARGIN:         y_margin_q <= cfg_data_i[MARGIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Place the rectangle: wrap check, sheet close, placement, group close
  always_comb begin
    sum_x  = SUM_W'(cursor_x_q) + SUM_W'(rect_width_i) + SUM_W'(x_margin_q);
    wrap   = sum_x > SUM_W'(max_w_q);
    wrap_y = sat_pos(SUM_W'(cursor_y_q) + SUM_W'(row_height_q) + SUM_W'(y_margin_q));

    cy1 = wrap ? wrap_y : cursor_y_q;
    cx1 = wrap ? xm_pos : cursor_x_q;
    rh1 = wrap ? '0 : row_height_q;
    eh1 = (wrap && wrap_y > extent_h_q) ? wrap_y : extent_h_q;

    close = wrap && (SUM_W'(eh1) > SUM_W'(max_h_q));
    ew2   = close ? '0 : extent_w_q;
    eh2   = close ? '0 : eh1;
    cy2   = close ? ym_pos : cy1;
    sc2   = close ? sheet_q + 1'b1 : sheet_q;

    rh3   = (rect_height_i > rh1) ? rect_height_i : rh1;
    cx3   = sat_pos(SUM_W'(cx1) + SUM_W'(rect_width_i) + SUM_W'(x_margin_q));
    ew3   = (cx3 > ew2) ? cx3 : ew2;
    fin_y = sat_pos(SUM_W'(cy2) + SUM_W'(rh3) + SUM_W'(y_margin_q));
    eh4   = (fin_y > eh2) ? fin_y : eh2;

    q_rec_o.wrap_close = close;
    q_rec_o.last       = group_end_i;
    q_rec_o.prev_sheet = sheet_q;
    q_rec_o.sheet      = sc2;
    q_rec_o.px         = cx1;
    q_rec_o.py         = cy2;
    q_rec_o.cw         = extent_w_q;
    q_rec_o.ch         = eh1;
    q_rec_o.fw         = ew3;
    q_rec_o.fh         = eh4;

    // Advance state; the last rectangle of a group restarts the packer
    if (group_end_i) begin
      cursor_x_d   = xm_pos;
      cursor_y_d   = ym_pos;
      row_height_d = '0;
      extent_w_d   = '0;
      extent_h_d   = '0;
      sheet_d      = '0;
    end else begin
      cursor_x_d   = cx3;
      cursor_y_d   = cy2;
      row_height_d = rh3;
      extent_w_d   = ew3;
      extent_h_d   = eh2;
      sheet_d      = sc2;
    end
  end

  // Hold packing state between transfers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q   <= POS_BITS'(MARGIN_RESET);
      cursor_y_q   <= POS_BITS'(MARGIN_RESET);
      row_height_q <= '0;
      extent_w_q   <= '0;
      extent_h_q   <= '0;
      sheet_q      <= '0;
    end else if (accept) begin
      cursor_x_q   <= cursor_x_d;
      cursor_y_q   <= cursor_y_d;
      row_height_q <= row_height_d;
      extent_w_q   <= extent_w_d;
      extent_h_q   <= extent_h_d;
      sheet_q      <= sheet_d;
    end
  end

endmodule

// File: design/srp_fifo.sv
// Short record queue that decouples the placement front end from the result back end.
// Depends on srp_pkg for the queue depth.
`timescale 1ns / 1ps

module srp_fifo
  import srp_pkg::*;
#(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]    mem_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_BITS-1:0] count_q;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CNT_BITS'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store pushed records
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: design/srp_back.sv
// Back end: walks each queued record through its one to three results.
// Depends on srp_pkg; drives the registered result channel.
`timescale 1ns / 1ps

module srp_back
  import srp_pkg::*;
#(
  parameter int unsigned DIM_BITS = 16,
  parameter type rec_t = logic
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  rec_t                  head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  kind_o,
  output logic [DIM_BITS+1:0]   x_offset_o,
  output logic [DIM_BITS+1:0]   y_offset_o,
  output logic [SHEET_BITS-1:0] sheet_number_o,
  output logic [DIM_BITS+1:0]   sheet_width_o,
  output logic [DIM_BITS+1:0]   sheet_height_o,
  output logic                  final_res_o
);

  localparam int unsigned POS_BITS = DIM_BITS + 2;

  phase_e phase_q, phase_d;

  logic                  load;
  kind_e                 res_kind;
  logic [POS_BITS-1:0]   res_x, res_y, res_w, res_h;
  logic [SHEET_BITS-1:0] res_sheet;
  logic                  res_final;

  logic                  out_valid_q;
  kind_e                 kind_q;
  logic [POS_BITS-1:0]   x_q, y_q, w_q, h_q;
  logic [SHEET_BITS-1:0] sheet_q;
  logic                  final_q;

  // Load the output register when it is empty or being drained
  assign load = head_valid_i && (!out_valid_q || out_ready_i);

  // Phase register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Select the current result of the head record and the next phase
  always_comb begin
    phase_d   = phase_q;
    pop_o     = 1'b0;
    res_kind  = KIND_PLACE;
    res_x     = head_i.px;
    res_y     = head_i.py;
    res_w     = '0;
    res_h     = '0;
    res_sheet = head_i.sheet;
    res_final = !head_i.last;
    case (phase_q)
      PH_START: begin
        if (head_i.wrap_close) begin
          res_kind  = KIND_SHEET;
          res_x     = '0;
          res_y     = '0;
          res_w     = head_i.cw;
          res_h     = head_i.ch;
          res_sheet = head_i.prev_sheet;
          res_final = 1'b0;
          if (load) phase_d = PH_PLACE;
        end else if (head_i.last) begin
          if (load) phase_d = PH_FINAL;
        end else begin
          pop_o = load;
        end
      end
      PH_PLACE: begin
        if (head_i.last) begin
          if (load) phase_d = PH_FINAL;
        end else begin
          pop_o = load;
          if (load) phase_d = PH_START;
        end
      end
      PH_FINAL: begin
        res_kind  = KIND_SHEET;
        res_x     = '0;
        res_y     = '0;
        res_w     = head_i.fw;
        res_h     = head_i.fh;
        res_final = 1'b1;
        pop_o     = load;
        if (load) phase_d = PH_START;
      end
      default: begin
        phase_d = PH_START;
      end
    endcase
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= res_kind;
      x_q     <= res_x;
      y_q     <= res_y;
      w_q     <= res_w;
      h_q     <= res_h;
      sheet_q <= res_sheet;
      final_q <= res_final;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign x_offset_o     = x_q;
  assign y_offset_o     = y_q;
  assign sheet_number_o = sheet_q;
  assign sheet_width_o  = w_q;
  assign sheet_height_o = h_q;
  assign final_res_o    = final_q;

endmodule

// File: design/srp_checker.sv
// Port-level checks for the shelf packing sprite layout block, bound to the top level.
// Depends on srp_pkg and the top level's ports.
`timescale 1ns / 1ps

module srp_checker
  import srp_pkg::*;
#(
  parameter int unsigned DIM_BITS = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic                  kind_o,
  input logic [DIM_BITS+1:0]   x_offset_o,
  input logic [DIM_BITS+1:0]   y_offset_o,
  input logic [SHEET_BITS-1:0] sheet_number_o,
  input logic [DIM_BITS+1:0]   sheet_width_o,
  input logic [DIM_BITS+1:0]   sheet_height_o,
  input logic                  final_res_o
);

  // A stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o)
      && $stable(x_offset_o) && $stable(y_offset_o) && $stable(sheet_number_o)
      && $stable(sheet_width_o) && $stable(sheet_height_o) && $stable(final_res_o))
    else $error("result changed while stalled");

  // Placements carry no sheet size
  a_place_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_PLACE |-> sheet_width_o == '0 && sheet_height_o == '0)
    else $error("placement with nonzero sheet size");

  // Sheet results carry no offsets
  a_sheet_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_SHEET |-> x_offset_o == '0 && y_offset_o == '0)
    else $error("sheet result with nonzero offsets");

  // A sheet closed by a row wrap is followed at once by a placement on the next sheet
  a_wrap_then_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && kind_o == KIND_SHEET && !final_res_o
      |=> out_valid_o && kind_o == KIND_PLACE
        && sheet_number_o == $past(sheet_number_o) + 1'b1)
    else $error("wrap close not followed by placement on next sheet");

endmodule

bind shelf_packing_sprite_layout srp_checker #(
  .DIM_BITS (DIM_BITS)
) u_srp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .kind_o         (kind_o),
  .x_offset_o     (x_offset_o),
  .y_offset_o     (y_offset_o),
  .sheet_number_o (sheet_number_o),
  .sheet_width_o  (sheet_width_o),
  .sheet_height_o (sheet_height_o),
  .final_res_o    (final_res_o)
);
